FILE: rtl/lhfm_pkg.sv
// ----------------------------------------------------------------------------
// lhfm_pkg: shared types and constants of the loop health fault monitor
// Register codes, configuration bundle, report and flag layouts.
// ----------------------------------------------------------------------------
package lhfm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 8;

    localparam logic [15:0] CNT_MAX    = 16'hFFFF;
    localparam logic [7:0]  STREAK_MAX = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_MS      = 3'd0,
        CFG_LOOP_BUDGET_US = 3'd1,
        CFG_OVERRUN_LIMIT  = 3'd2,
        CFG_OVERFLOW_LIMIT = 3'd3,
        CFG_RECOVERY_LIMIT = 3'd4,
        CFG_RESTART_TIME   = 3'd5,
        CFG_RESTART_STREAK = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] window_ms;
        logic [31:0] loop_budget_us;
        logic [15:0] overrun_limit;
        logic [15:0] overflow_limit;
        logic [31:0] recovery_limit;
        logic [31:0] restart_time_us;
        logic [7:0]  restart_streak_len;
    } t_cfg;

    // Field order mirrors tdata from the high bits down.
    typedef struct packed {
        logic [31:0] recovery_total;
        logic [31:0] overflow_total_b;
        logic [31:0] overflow_total_a;
        logic [31:0] now_ms;
        logic [31:0] loop_time_us;
    } t_report;

    typedef struct packed {
        logic restart_request;
        logic force_offline;
        logic sensor_b_degraded;
        logic sensor_a_degraded;
        logic degraded_mode;
    } t_flags;

endpackage

FILE: rtl/loop_health_fault_monitor_unit.sv
// ----------------------------------------------------------------------------
// loop_health_fault_monitor_unit: per-loop health and fault flag generator
// Input register, single-pass flag logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one report beat per completed control loop; m_axis returns
//   one flag beat per report, in order. The write port loads the seven limit
//   and window registers; write only while no report is in flight.
//   A report is held in the input register, then goes through the window
//   counters into the result register. Throughput: one report per cycle
//   while m_axis_tready is high, set by that single pass.
//   Reset: synchronous, active low; clears all windows, counts, the streak
//   and the degraded latch, loads register defaults and empties both stages.
//   Stall: with m_axis_tready low the result holds, the input register still
//   takes one more beat, then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module loop_health_fault_monitor_unit
    import lhfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // loop_time_us, now_ms, overflow_total_a, overflow_total_b, recovery_total
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // degraded_mode, sensor_a_degraded, sensor_b_degraded, force_offline,
    // restart_request, 3 zero bits
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cfg    cfg;
    t_report r_in;
    logic    r_in_valid;
    t_flags  r_out;
    logic    r_out_valid;
    t_flags  n_out;
    logic    fire;
    logic    in_take;

    lhfm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // advance the held report into the result register
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= t_report'(s_axis_tdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    lhfm_overrun u_overrun (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (fire),
        .i_now       (r_in.now_ms),
        .i_loop_time (r_in.loop_time_us),
        .i_cfg       (cfg),
        .o_degraded  (n_out.degraded_mode),
        .o_restart   (n_out.restart_request)
    );

    lhfm_rate_win u_win_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (fire),
        .i_now      (r_in.now_ms),
        .i_total    (r_in.overflow_total_a),
        .i_window   (cfg.window_ms),
        .i_limit    (cfg.overflow_limit),
        .o_degraded (n_out.sensor_a_degraded)
    );

    lhfm_rate_win u_win_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (fire),
        .i_now      (r_in.now_ms),
        .i_total    (r_in.overflow_total_b),
        .i_window   (cfg.window_ms),
        .i_limit    (cfg.overflow_limit),
        .o_degraded (n_out.sensor_b_degraded)
    );

    assign n_out.force_offline = (r_in.recovery_total > cfg.recovery_limit);

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

`ifndef ASSERT_OFF
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input side stalled with empty input register");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid)
        else $error("held report dropped before reaching the result register");

    a_result_from_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_in_valid))
        else $error("result raised without a held report");
`endif

endmodule

FILE: rtl/lhfm_cfg.sv
// ----------------------------------------------------------------------------
// lhfm_cfg: configuration register file
// Write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
module lhfm_cfg
    import lhfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_MS:      n_cfg.window_ms          = i_cfg_data[15:0];
                CFG_LOOP_BUDGET_US: n_cfg.loop_budget_us     = i_cfg_data;
                CFG_OVERRUN_LIMIT:  n_cfg.overrun_limit      = i_cfg_data[15:0];
                CFG_OVERFLOW_LIMIT: n_cfg.overflow_limit     = i_cfg_data[15:0];
                CFG_RECOVERY_LIMIT: n_cfg.recovery_limit     = i_cfg_data;
                CFG_RESTART_TIME:   n_cfg.restart_time_us    = i_cfg_data;
                CFG_RESTART_STREAK: n_cfg.restart_streak_len = i_cfg_data[7:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms          <= 16'd1000;
            r_cfg.loop_budget_us     <= 32'd10000;
            r_cfg.overrun_limit      <= 16'd10;
            r_cfg.overflow_limit     <= 16'd5;
            r_cfg.recovery_limit     <= 32'd10;
            r_cfg.restart_time_us    <= 32'd20000;
            r_cfg.restart_streak_len <= 8'd3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/lhfm_rate_win.sv
// ----------------------------------------------------------------------------
// lhfm_rate_win: windowed rate counter of one overflow total
// Adds each increase of the total, clears on window expiry.
// ----------------------------------------------------------------------------
module lhfm_rate_win
    import lhfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [31:0] i_now,
    input  logic [31:0] i_total,
    input  logic [15:0] i_window,
    input  logic [15:0] i_limit,
    output logic        o_degraded
);

    logic [31:0] r_start;
    logic [31:0] r_base;
    logic [15:0] r_cnt;
    logic [31:0] n_start;
    logic [31:0] n_base;
    logic [15:0] n_cnt;

    logic [31:0] start0;
    logic [31:0] base0;
    logic [31:0] delta;
    logic [31:0] elapsed;

    always_comb begin
        // a zero start time reads as not started
        start0  = (r_start == 32'd0) ? i_now : r_start;
        base0   = (r_start == 32'd0) ? i_total : r_base;
        delta   = i_total - base0;
        elapsed = i_now - start0;
        n_start = start0;
        n_base  = base0;
        n_cnt   = r_cnt;
        if (i_total > base0) begin
            n_cnt  = r_cnt + delta[15:0];
            n_base = i_total;
        end
        if (elapsed >= {16'd0, i_window}) begin
            n_start = i_now;
            n_cnt   = 16'd0;
            n_base  = i_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 32'd0;
            r_base  <= 32'd0;
            r_cnt   <= 16'd0;
        end else if (i_en) begin
            r_start <= n_start;
            r_base  <= n_base;
            r_cnt   <= n_cnt;
        end
    end

    assign o_degraded = (n_cnt > i_limit);

endmodule

FILE: rtl/lhfm_overrun.sv
// ----------------------------------------------------------------------------
// lhfm_overrun: overrun window, degraded latch and long-loop streak
// Counts budget overruns per window and tracks consecutive long loops.
// ----------------------------------------------------------------------------
module lhfm_overrun
    import lhfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [31:0] i_now,
    input  logic [31:0] i_loop_time,
    input  t_cfg        i_cfg,
    output logic        o_degraded,
    output logic        o_restart
);

    logic [31:0] r_start;
    logic [15:0] r_cnt;
    logic        r_latch;
    logic [7:0]  r_streak;
    logic [31:0] n_start;
    logic [15:0] n_cnt;
    logic        n_latch;
    logic [7:0]  n_streak;

    logic [31:0] start0;
    logic [31:0] elapsed;

    always_comb begin
        start0  = (r_start == 32'd0) ? i_now : r_start;
        elapsed = i_now - start0;
        n_start = start0;
        n_cnt   = r_cnt;
        if (elapsed >= {16'd0, i_cfg.window_ms}) begin
            n_start = i_now;
            n_cnt   = 16'd0;
        end
        if ((i_loop_time > i_cfg.loop_budget_us) && (n_cnt != CNT_MAX)) begin
            n_cnt = n_cnt + 16'd1;
        end
        n_latch = r_latch | (n_cnt > i_cfg.overrun_limit);

        if (i_loop_time > i_cfg.restart_time_us) begin
            n_streak = (r_streak == STREAK_MAX) ? r_streak : r_streak + 8'd1;
        end else begin
            n_streak = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= 32'd0;
            r_cnt    <= 16'd0;
            r_latch  <= 1'b0;
            r_streak <= 8'd0;
        end else if (i_en) begin
            r_start  <= n_start;
            r_cnt    <= n_cnt;
            r_latch  <= n_latch;
            r_streak <= n_streak;
        end
    end

    assign o_degraded = n_latch;
    assign o_restart  = (n_streak >= i_cfg.restart_streak_len);

`ifndef ASSERT_OFF
    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latch |=> r_latch)
        else $error("degraded latch cleared without reset");
`endif

endmodule

FILE: sim/tb_loop_health_fault_monitor_unit.sv
// ----------------------------------------------------------------------------
// tb_loop_health_fault_monitor_unit: self-checking bench of the fault monitor
// Streams loop reports through the unit under bursty input and a stalling
// output, predicts the fault flags of every accepted report with a local copy
// of the window, streak and latch state, and checks each flag beat in order.
// ----------------------------------------------------------------------------
module tb_loop_health_fault_monitor_unit;
    import lhfm_pkg::*;

    localparam int                   CYCLE_LIMIT   = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // loop_time_us, now_ms, overflow_total_a, overflow_total_b, recovery_total
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // degraded_mode, sensor_a_degraded, sensor_b_degraded, force_offline,
    // restart_request, 3 zero bits
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    loop_health_fault_monitor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Register mirror, loaded with the reset defaults
    logic [15:0] cfg_window   = 16'd1000;
    logic [31:0] cfg_budget   = 32'd10000;
    logic [15:0] cfg_ovr_lim  = 16'd10;
    logic [15:0] cfg_ovf_lim  = 16'd5;
    logic [31:0] cfg_rec_lim  = 32'd10;
    logic [31:0] cfg_rst_time = 32'd20000;
    logic [7:0]  cfg_streak   = 8'd3;

    // Monitor state as it stands after reset
    logic [31:0] ovr_start = '0;
    logic [15:0] ovr_count = '0;
    logic [31:0] port_start [2] = '{32'd0, 32'd0};
    logic [31:0] port_base  [2] = '{32'd0, 32'd0};
    logic [15:0] port_count [2] = '{16'd0, 16'd0};
    logic [7:0]  long_streak = '0;
    logic        degraded = 1'b0;

    t_report report_q [$];
    t_flags  flags_due_q [$];

    // Running values of the report generator
    logic [31:0] gen_now = 32'd2000;
    logic [31:0] gen_a = '0;
    logic [31:0] gen_b = '0;
    logic [31:0] gen_rec = '0;
    logic        gen_long_loops = 1'b0;

    int    err_cnt = 0;
    int    got_cnt = 0;
    int    cycle_cnt = 0;
    int    gap_left = 0;
    int    burst_left = 0;
    int    hold_left = 0;
    bit    hold_done = 1'b0;
    int    pat_left = 0;
    int    pat_mode = 0;
    logic [15:0] stall_pat = '1;
    t_flags flag_want;
    t_flags flag_seen;
    string  flag_name [5] = '{"degraded_mode", "sensor_a_degraded", "sensor_b_degraded",
                              "force_offline", "restart_request"};

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_flags predict_flags(t_report rpt);
        t_flags      f;
        logic [31:0] total;
        logic [31:0] elapsed;
        logic [31:0] rise;
        if (ovr_start == 32'd0) begin
            ovr_start = rpt.now_ms;
        end
        elapsed = rpt.now_ms - ovr_start;
        if (elapsed >= {16'd0, cfg_window}) begin
            ovr_start = rpt.now_ms;
            ovr_count = '0;
        end
        if (rpt.loop_time_us > cfg_budget && ovr_count != CNT_MAX) begin
            ovr_count = ovr_count + 16'd1;
        end
        if (ovr_count > cfg_ovr_lim) begin
            degraded = 1'b1;
        end
        for (int p = 0; p < 2; p++) begin
            total = (p == 0) ? rpt.overflow_total_a : rpt.overflow_total_b;
            if (port_start[p] == 32'd0) begin
                port_start[p] = rpt.now_ms;
                port_base[p]  = total;
            end
            // a total that went backwards adds nothing and keeps its baseline
            if (total > port_base[p]) begin
                rise          = total - port_base[p];
                port_count[p] = port_count[p] + rise[15:0];
                port_base[p]  = total;
            end
            elapsed = rpt.now_ms - port_start[p];
            if (elapsed >= {16'd0, cfg_window}) begin
                port_start[p] = rpt.now_ms;
                port_count[p] = '0;
                port_base[p]  = total;
            end
        end
        if (rpt.loop_time_us > cfg_rst_time) begin
            if (long_streak != STREAK_MAX) begin
                long_streak = long_streak + 8'd1;
            end
        end else begin
            long_streak = '0;
        end
        f.degraded_mode     = degraded;
        f.sensor_a_degraded = port_count[0] > cfg_ovf_lim;
        f.sensor_b_degraded = port_count[1] > cfg_ovf_lim;
        f.force_offline     = rpt.recovery_total > cfg_rec_lim;
        f.restart_request   = long_streak >= cfg_streak;
        return f;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %0s at flag beat %0d: got %0h, want %0h", what, got_cnt, got,
                 want);
        err_cnt++;
    endtask

    task automatic push_report(logic [31:0] lt, logic [31:0] nw, logic [31:0] ta,
                               logic [31:0] tb, logic [31:0] rec);
        t_report r;
        r.loop_time_us     = lt;
        r.now_ms           = nw;
        r.overflow_total_a = ta;
        r.overflow_total_b = tb;
        r.recovery_total   = rec;
        report_q.push_back(r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_WINDOW_MS:      cfg_window   = val[15:0];
            CFG_LOOP_BUDGET_US: cfg_budget   = val;
            CFG_OVERRUN_LIMIT:  cfg_ovr_lim  = val[15:0];
            CFG_OVERFLOW_LIMIT: cfg_ovf_lim  = val[15:0];
            CFG_RECOVERY_LIMIT: cfg_rec_lim  = val;
            CFG_RESTART_TIME:   cfg_rst_time = val;
            CFG_RESTART_STREAK: cfg_streak   = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] next_total(logic [31:0] total);
        case ($urandom_range(0, 15))
            0:       return total - $urandom_range(1, 20);
            1:       return $urandom;
            2:       return total + $urandom_range(0, 70000);
            default: return total + $urandom_range(0, 2);
        endcase
    endfunction

    task automatic add_reports(int n);
        logic [31:0] lt;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0:       lt = '0;
                1:       lt = '1;
                2:       lt = $urandom;
                3:       lt = cfg_budget + $urandom_range(0, 2) - 1;
                4:       lt = cfg_rst_time + $urandom_range(0, 2) - 1;
                5, 6:    lt = $urandom_range(0, cfg_budget);
                7, 8:    lt = cfg_rst_time + $urandom_range(1, 1000);
                default: lt = cfg_budget + $urandom_range(1, 5000);
            endcase
            if (gen_long_loops) begin
                lt[0] = 1'b1;
            end
            case ($urandom_range(0, 15))
                0:       ;
                1:       gen_now = gen_now + cfg_window;
                2:       gen_now = gen_now + cfg_window - 1;
                3:       gen_now = gen_now + $urandom;
                4:       gen_now = '0;
                default: gen_now = gen_now + $urandom_range(0, cfg_window / 8 + 1);
            endcase
            gen_a = next_total(gen_a);
            gen_b = next_total(gen_b);
            case ($urandom_range(0, 7))
                0:       gen_rec = $urandom;
                1:       gen_rec = cfg_rec_lim;
                2:       gen_rec = cfg_rec_lim + 1;
                3:       gen_rec = cfg_rec_lim - 1;
                default: gen_rec = gen_rec + $urandom_range(0, 1);
            endcase
            push_report(lt, gen_now, gen_a, gen_b, gen_rec);
        end
    endtask

    task automatic wait_idle();
        while (report_q.size() != 0 || s_axis_tvalid || flags_due_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_reports(int n);
        @(negedge i_clk);
        add_reports(n);
        wait_idle();
    endtask

    task automatic shuffle_limits();
        logic [31:0] v;
        v       = $urandom;
        v[15:0] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
        write_reg(CFG_WINDOW_MS, v);
        v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 30000);
        write_reg(CFG_LOOP_BUDGET_US, v);
        v       = $urandom;
        v[15:0] = 16'($urandom_range(0, 20));
        write_reg(CFG_OVERRUN_LIMIT, v);
        v       = $urandom;
        v[15:0] = 16'($urandom_range(0, 20));
        write_reg(CFG_OVERFLOW_LIMIT, v);
        write_reg(CFG_RECOVERY_LIMIT, gen_rec + $urandom_range(0, 8) - 4);
        write_reg(CFG_RESTART_TIME, $urandom_range(0, 40000));
        v      = $urandom;
        v[7:0] = 8'($urandom_range(0, 6));
        write_reg(CFG_RESTART_STREAK, v);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // timestamp zero leaves the windows unstarted
        push_report(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        push_report(32'd20001, 32'd0, 32'd3, 32'd0, 32'd10);
        push_report(32'd20001, 32'd5, 32'd10, 32'd0, 32'd11);
        push_report(32'd20001, 32'd6, 32'd20, 32'd70000, 32'd10);
        // totals going backwards, loop time right at the budget
        push_report(32'd10000, 32'd7, 32'd15, 32'd70000, 32'd9);
        push_report(32'd10001, 32'd8, 32'd15, 32'd69999, 32'd0);
        push_report('1, '1, '1, '1, '1);
        // timestamp wraps inside the window, then expires exactly
        push_report('1, 32'd998, '1, '1, '1);
        push_report(32'd0, 32'd999, 32'd5, 32'd5, 32'd0);
        // enough overruns in one window to latch degraded mode
        for (int i = 0; i < 12; i++) begin
            push_report(32'd10001, 32'd1000 + i, 32'd20, 32'd70000, 32'd0);
        end
        wait_idle();

        run_reports(250);

        // low extremes: every report expires the windows, streak length zero
        write_reg(CFG_WINDOW_MS, 32'd0);
        write_reg(CFG_LOOP_BUDGET_US, '1);
        write_reg(CFG_OVERRUN_LIMIT, 32'd0);
        write_reg(CFG_OVERFLOW_LIMIT, 32'd0);
        write_reg(CFG_RECOVERY_LIMIT, '1);
        write_reg(CFG_RESTART_TIME, '1);
        write_reg(CFG_RESTART_STREAK, 32'd0);
        write_reg(CFG_IDX_SPARE, $urandom);
        run_reports(150);

        // high extremes: run the streak into saturation
        write_reg(CFG_WINDOW_MS, '1);
        write_reg(CFG_LOOP_BUDGET_US, 32'd0);
        write_reg(CFG_OVERRUN_LIMIT, '1);
        write_reg(CFG_OVERFLOW_LIMIT, '1);
        write_reg(CFG_RECOVERY_LIMIT, 32'd0);
        write_reg(CFG_RESTART_TIME, 32'd0);
        write_reg(CFG_RESTART_STREAK, '1);
        gen_long_loops = 1'b1;
        run_reports(300);
        gen_long_loops = 1'b0;

        for (int k = 0; k < 5; k++) begin
            shuffle_limits();
            run_reports(105);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (flags_due_q.size() != 0) begin
            report_mismatch("flag beats never delivered", 32'd0, flags_due_q.size());
        end
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Sender: bursts of random length with random gaps, valid held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (report_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= report_q.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 16);
                    gap_left   = $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: a randomly redrawn stall pattern, plus long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && got_cnt >= 200) begin
            hold_done = 1'b1;
            hold_left = $urandom_range(40, 80);
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 599) == 0) begin
            hold_left = $urandom_range(30, 60);
            m_axis_tready <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                pat_left  = 64;
                pat_mode  = $urandom_range(0, 3);
                stall_pat = 16'($urandom);
            end
            pat_left--;
            case (pat_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= stall_pat[pat_left % 16];
            endcase
        end
    end

    // Predict on every accepted report, then check the flag beat if one is taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                flags_due_q.push_back(predict_flags(t_report'(s_axis_tdata)));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_cnt++;
                if (flags_due_q.size() == 0) begin
                    report_mismatch("flag beat with no report pending", m_axis_tdata, 32'd0);
                end else begin
                    flag_want = flags_due_q.pop_front();
                    flag_seen = t_flags'(m_axis_tdata[4:0]);
                    for (int i = 0; i < 5; i++) begin
                        if (flag_seen[i] !== flag_want[i]) begin
                            report_mismatch(flag_name[i], flag_seen[i], flag_want[i]);
                        end
                    end
                    if (m_axis_tdata[7:5] !== 3'd0) begin
                        report_mismatch("padding bits", m_axis_tdata[7:5], 32'd0);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILURE");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/lhfm_pkg.sv
rtl/lhfm_cfg.sv
rtl/lhfm_rate_win.sv
rtl/lhfm_overrun.sv
rtl/loop_health_fault_monitor_unit.sv
sim/tb_loop_health_fault_monitor_unit.sv
